>>> rtl/core/u8dec_pkg.sv
package u8dec_pkg;

    localparam int unsigned CpWidth   = 21;
    localparam int unsigned UsedWidth = 3;

    localparam logic [CpWidth-1:0]   ReplChar  = 21'h00FFFD;
    localparam logic [CpWidth-1:0]   MaxScalar = 21'h10FFFF;

    localparam logic [UsedWidth-1:0] UsedOne   = 3'd1;
    localparam logic [UsedWidth-1:0] UsedTwo   = 3'd2;
    localparam logic [UsedWidth-1:0] UsedThree = 3'd3;
    localparam logic [UsedWidth-1:0] UsedFour  = 3'd4;

    typedef struct packed {
        logic [7:0] lead_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
        logic [7:0] fourth_byte;
    } t_window;

    typedef struct packed {
        logic [CpWidth-1:0]   code_point;
        logic [UsedWidth-1:0] bytes_used;
        logic                 replaced;
    } t_result;

    function automatic logic is_cont(input logic [7:0] b);
        is_cont = (b[7:6] == 2'b10);
    endfunction

endpackage

>>> rtl/core/utf8_rune_decoder_core.sv
// Channel  Dir  Handshake                Payload
// in       in   i_in_valid/o_in_stall    i_lead_byte, i_second_byte, i_third_byte, i_fourth_byte
// out      out  o_out_valid/i_out_stall  o_code_point, o_bytes_used, o_replaced
//
// One request is accepted per cycle while o_in_stall is low; the window is captured
// in an input register, decoded by shallow logic, and held in a result register
// before it is presented, so the rate is set by that single register-to-register path.
// Reset is synchronous and active low and clears both valid flags.
// A stalled result holds in the result register while the input register still
// takes one more request; input stalls only when both registers are full and the
// output is stalled.
module utf8_rune_decoder_core
    import u8dec_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_lead_byte,
    input  logic [7:0]           i_second_byte,
    input  logic [7:0]           i_third_byte,
    input  logic [7:0]           i_fourth_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CpWidth-1:0]   o_code_point,
    output logic [UsedWidth-1:0] o_bytes_used,
    output logic                 o_replaced
);

    logic    r_s1_valid;
    logic    n_s1_valid;
    t_window r_window;
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_result;
    t_result dec_result;
    logic    out_load;
    logic    s1_load;

    assign out_load   = !r_out_valid || !i_out_stall;
    assign s1_load    = !r_s1_valid || out_load;
    assign o_in_stall = !s1_load;

    assign n_s1_valid  = s1_load ? i_in_valid : r_s1_valid;
    assign n_out_valid = out_load ? r_s1_valid : r_out_valid;

    u8dec_decode u_decode (
        .i_window (r_window),
        .o_result (dec_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load && i_in_valid) begin
            r_window <= '{lead_byte: i_lead_byte, second_byte: i_second_byte,
                          third_byte: i_third_byte, fourth_byte: i_fourth_byte};
        end
        if (out_load && r_s1_valid) begin
            r_result <= dec_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_code_point = r_result.code_point;
    assign o_bytes_used = r_result.bytes_used;
    assign o_replaced   = r_result.replaced;

    a_repl_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_replaced) |-> (o_code_point == ReplChar && o_bytes_used == UsedOne))
        else $error("Replacement result has the wrong code point or length.");

    a_valid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_replaced) |-> (o_code_point <= MaxScalar &&
            (o_bytes_used == UsedOne || o_bytes_used == UsedTwo ||
             o_bytes_used == UsedThree || o_bytes_used == UsedFour)))
        else $error("Decoded result is out of range.");

    a_ascii_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_replaced && o_bytes_used == UsedOne) |-> (o_code_point < 21'h80))
        else $error("Single-byte result is not ASCII.");

    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && o_out_valid && i_out_stall) |=> r_s1_valid)
        else $error("Pending request dropped under stall.");

endmodule

>>> rtl/core/u8dec_decode.sv
module u8dec_decode
    import u8dec_pkg::*;
(
    input  t_window i_window,
    output t_result o_result
);

    logic [7:0]         b0;
    logic [7:0]         b1;
    logic [7:0]         b2;
    logic [7:0]         b3;
    logic [CpWidth-1:0] cp_two;
    logic [CpWidth-1:0] cp_three;
    logic [CpWidth-1:0] cp_four;
    t_result            bad;

    assign b0 = i_window.lead_byte;
    assign b1 = i_window.second_byte;
    assign b2 = i_window.third_byte;
    assign b3 = i_window.fourth_byte;

    assign cp_two   = {10'd0, b0[4:0], b1[5:0]};
    assign cp_three = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
    assign cp_four  = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};

    assign bad = '{code_point: ReplChar, bytes_used: UsedOne, replaced: 1'b1};

    always_comb begin
        o_result = bad;
        if (b0[7] == 1'b0) begin
            o_result = '{code_point: {13'd0, b0}, bytes_used: UsedOne, replaced: 1'b0};
        end else if (b0[7:5] == 3'b110) begin
            if (is_cont(b1)) begin
                o_result = '{code_point: cp_two, bytes_used: UsedTwo, replaced: 1'b0};
            end
        end else if (b0[7:4] == 4'b1110) begin
            if (is_cont(b1) && is_cont(b2)) begin
                o_result = '{code_point: cp_three, bytes_used: UsedThree, replaced: 1'b0};
            end
        end else if (b0[7:3] == 5'b11110) begin
            if (is_cont(b1) && is_cont(b2) && is_cont(b3) && (cp_four <= MaxScalar)) begin
                o_result = '{code_point: cp_four, bytes_used: UsedFour, replaced: 1'b0};
            end
        end
    end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import u8dec_pkg::*;

    localparam int HalfPeriod     = 10;
    localparam int ResetCycles    = 12;
    localparam int RandomRequests = 700;
    localparam int IdleLimit      = 2000;
    localparam int DrainCycles    = 8;

    typedef struct packed {
        t_window              win;
        logic                 typed;
        logic [CpWidth-1:0]   cp;
        logic [UsedWidth-1:0] used;
        logic                 repl;
    } t_window_row;

    typedef enum int unsigned {
        StallNone,
        StallLight,
        StallPeriodic,
        StallHeavy
    } t_stall_mode;

    // Rows with typed set carry an expectation read straight off the decoding rules.
    localparam t_window_row DirectedRows [25] = '{
        '{32'h00000000, 1'b1, 21'h000000, UsedOne, 1'b0},
        '{32'h7FFFFFFF, 1'b1, 21'h00007F, UsedOne, 1'b0},
        '{32'h80808080, 1'b1, ReplChar,   UsedOne, 1'b1},
        '{32'hBF808080, 1'b1, ReplChar,   UsedOne, 1'b1},
        '{32'hF8808080, 1'b1, ReplChar,   UsedOne, 1'b1},
        '{32'hFFFFFFFF, 1'b1, ReplChar,   UsedOne, 1'b1},
        '{32'hC2A90000, 1'b0, 21'h000000, UsedOne, 1'b0},
        '{32'hC0800000, 1'b0, 21'h000000, UsedOne, 1'b0},
        '{32'hDFBF0000, 1'b0, 21'h000000, UsedOne, 1'b0},
        '{32'hC3000000, 1'b1, ReplChar,   UsedOne, 1'b1},
        '{32'hC3C00000, 1'b1, ReplChar,   UsedOne, 1'b1},
        '{32'hE282AC00, 1'b0, 21'h000000, UsedOne, 1'b0},
        '{32'hE0808000, 1'b0, 21'h000000, UsedOne, 1'b0},
        '{32'hEDA08000, 1'b0, 21'h000000, UsedOne, 1'b0},
        '{32'hEFBFBF00, 1'b0, 21'h000000, UsedOne, 1'b0},
        '{32'hE2820000, 1'b1, ReplChar,   UsedOne, 1'b1},
        '{32'hE27FAC00, 1'b1, ReplChar,   UsedOne, 1'b1},
        '{32'hF09F9880, 1'b0, 21'h000000, UsedOne, 1'b0},
        '{32'hF48FBFBF, 1'b0, 21'h000000, UsedOne, 1'b0},
        '{32'hF4908080, 1'b1, ReplChar,   UsedOne, 1'b1},
        '{32'hF7BFBFBF, 1'b1, ReplChar,   UsedOne, 1'b1},
        '{32'hF0808080, 1'b0, 21'h000000, UsedOne, 1'b0},
        '{32'hF09F9800, 1'b1, ReplChar,   UsedOne, 1'b1},
        '{32'hF09F2880, 1'b1, ReplChar,   UsedOne, 1'b1},
        '{32'h41FFFFFF, 1'b0, 21'h000000, UsedOne, 1'b0}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [7:0]           i_lead_byte;
    logic [7:0]           i_second_byte;
    logic [7:0]           i_third_byte;
    logic [7:0]           i_fourth_byte;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [CpWidth-1:0]   o_code_point;
    logic [UsedWidth-1:0] o_bytes_used;
    logic                 o_replaced;

    t_result     pending_runes [$];
    int unsigned mismatches  = 0;
    int unsigned idle_cycles = 0;
    int unsigned stall_cycle = 0;
    t_stall_mode stall_mode  = StallNone;

    utf8_rune_decoder_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_lead_byte   (i_lead_byte),
        .i_second_byte (i_second_byte),
        .i_third_byte  (i_third_byte),
        .i_fourth_byte (i_fourth_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_code_point  (o_code_point),
        .o_bytes_used  (o_bytes_used),
        .o_replaced    (o_replaced)
    );

    always #HalfPeriod i_clk = ~i_clk;

    function automatic t_result decode_rune(input t_window w);
        t_result            r;
        logic [CpWidth-1:0] cp;
        r = '{code_point: ReplChar, bytes_used: UsedOne, replaced: 1'b1};
        if (!w.lead_byte[7]) begin
            r = '{code_point: {14'd0, w.lead_byte[6:0]}, bytes_used: UsedOne, replaced: 1'b0};
        end else if (w.lead_byte[7:5] == 3'b110) begin
            if (w.second_byte[7:6] == 2'b10) begin
                cp = {10'd0, w.lead_byte[4:0], w.second_byte[5:0]};
                r = '{code_point: cp, bytes_used: UsedTwo, replaced: 1'b0};
            end
        end else if (w.lead_byte[7:4] == 4'b1110) begin
            if ({w.second_byte[7:6], w.third_byte[7:6]} == 4'b1010) begin
                cp = {5'd0, w.lead_byte[3:0], w.second_byte[5:0], w.third_byte[5:0]};
                r = '{code_point: cp, bytes_used: UsedThree, replaced: 1'b0};
            end
        end else if (w.lead_byte[7:3] == 5'b11110) begin
            if ({w.second_byte[7:6], w.third_byte[7:6], w.fourth_byte[7:6]} == 6'b101010)
            begin
                cp = {w.lead_byte[2:0], w.second_byte[5:0], w.third_byte[5:0],
                      w.fourth_byte[5:0]};
                if (cp <= MaxScalar) begin
                    r = '{code_point: cp, bytes_used: UsedFour, replaced: 1'b0};
                end
            end
        end
        return r;
    endfunction

    // Mostly well-formed sequences with random payload, some with one needed
    // continuation byte spoiled, and the rest raw noise.
    function automatic t_window random_window();
        logic [7:0]  b [4];
        int unsigned kind;
        int unsigned len;
        int unsigned spoil;
        int unsigned top;
        for (int i = 0; i < 4; i++) begin
            b[i] = 8'($urandom);
        end
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1:    len = 1;
            2:       len = 2;
            3, 4:    len = 3;
            5, 6:    len = 4;
            7:       len = $urandom_range(2, 4);
            default: len = 0;
        endcase
        case (len)
            1: b[0] = {1'b0, 7'($urandom)};
            2: b[0] = {3'b110, 5'($urandom)};
            3: b[0] = {4'b1110, 4'($urandom)};
            4: b[0] = {5'b11110, ($urandom_range(0, 3) == 0) ? 3'($urandom)
                                                               : 3'($urandom_range(0, 4))};
            default: ;
        endcase
        for (int i = 1; i < len; i++) begin
            b[i] = {2'b10, 6'($urandom)};
        end
        if (kind == 7) begin
            spoil = $urandom_range(1, len - 1);
            top   = $urandom_range(0, 2);
            if ($urandom_range(0, 2) == 0) begin
                b[spoil] = 8'h00;
            end else begin
                b[spoil] = {(top == 2) ? 2'b11 : 2'(top), 6'($urandom)};
            end
        end
        return {b[0], b[1], b[2], b[3]};
    endfunction

    task automatic send_window(input t_window w, input t_result want);
        i_in_valid <= 1'b1;
        {i_lead_byte, i_second_byte, i_third_byte, i_fourth_byte} <= w;
        do @(posedge i_clk); while (o_in_stall);
        pending_runes.push_back(want);
        @(negedge i_clk);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        if (cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_cycle % 48 == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
        end
        stall_cycle++;
        case (stall_mode)
            StallNone:     i_out_stall <= 1'b0;
            StallLight:    i_out_stall <= ($urandom_range(0, 99) < 30);
            StallPeriodic: i_out_stall <= (stall_cycle % 3 != 0);
            default:       i_out_stall <= ($urandom_range(0, 99) < 70);
        endcase
    end

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (o_out_valid && !i_out_stall) begin
                got = '{code_point: o_code_point, bytes_used: o_bytes_used,
                        replaced: o_replaced};
                if (pending_runes.size() == 0) begin
                    $display("%0t: result with none expected: %s %h %s %0d %s %b",
                             $time, "code_point", got.code_point, "bytes_used",
                             got.bytes_used, "replaced", got.replaced);
                    mismatches++;
                end else begin
                    want = pending_runes.pop_front();
                    if (got.code_point !== want.code_point) begin
                        $display("%0t: code_point expected %h, actual %h",
                                 $time, want.code_point, got.code_point);
                        mismatches++;
                    end
                    if (got.bytes_used !== want.bytes_used) begin
                        $display("%0t: bytes_used expected %0d, actual %0d",
                                 $time, want.bytes_used, got.bytes_used);
                        mismatches++;
                    end
                    if (got.replaced !== want.replaced) begin
                        $display("%0t: replaced expected %b, actual %b",
                                 $time, want.replaced, got.replaced);
                        mismatches++;
                    end
                end
            end
            if (idle_cycles >= IdleLimit) begin
                $display("%0t: no request moved for %0d cycles", $time, IdleLimit);
                $display("FAIL utf8_rune_decoder_core");
                $finish;
            end
        end
    end

    initial begin
        t_window     w;
        t_result     want;
        int unsigned burst_left;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_lead_byte   = 8'h00;
        i_second_byte = 8'h00;
        i_third_byte  = 8'h00;
        i_fourth_byte = 8'h00;
        repeat (ResetCycles) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DirectedRows[k]) begin
            w = DirectedRows[k].win;
            if (DirectedRows[k].typed) begin
                want = '{code_point: DirectedRows[k].cp, bytes_used: DirectedRows[k].used,
                         replaced: DirectedRows[k].repl};
            end else begin
                want = decode_rune(w);
            end
            send_window(w, want);
            if ($urandom_range(0, 3) == 0) begin
                pause_sender($urandom_range(1, 4));
            end
        end

        burst_left = 0;
        for (int n = 0; n < RandomRequests; n++) begin
            if (n == RandomRequests / 2) begin
                // The sender holds off here until every pending request has drained.
                i_in_valid <= 1'b0;
                do @(negedge i_clk); while (pending_runes.size() != 0);
            end
            if (burst_left == 0) begin
                if ($urandom_range(0, 7) == 0) begin
                    burst_left = $urandom_range(40, 80);
                end else begin
                    burst_left = $urandom_range(1, 16);
                end
                if ($urandom_range(0, 4) != 0) begin
                    pause_sender($urandom_range(1, 8));
                end
            end
            w = random_window();
            send_window(w, decode_rune(w));
            burst_left--;
        end

        i_in_valid <= 1'b0;
        while (pending_runes.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatches == 0 && pending_runes.size() == 0) begin
            $display("PASS utf8_rune_decoder_core");
        end else begin
            $display("FAIL utf8_rune_decoder_core");
        end
        $finish;
    end

endmodule
